### rtl/sled_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sled_pkg
// Shared types, character codes and helpers for the string literal escape
// decoder.
// ----------------------------------------------------------------------------
package sled_pkg;

    // One result beat
    typedef struct packed {
        logic [7:0] data;
        logic       is_end;
        logic       qerr;
    } res_t;

    // Hex digit lookup result
    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    localparam int unsigned MAX_RES = 3;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_V   = 8'h76;
    localparam logic [7:0] CH_LO_X   = 8'h78;
    localparam logic [7:0] CH_UP_X   = 8'h58;

    localparam logic [7:0] CODE_BS = 8'h08;
    localparam logic [7:0] CODE_FF = 8'h0C;
    localparam logic [7:0] CODE_NL = 8'h0A;
    localparam logic [7:0] CODE_CR = 8'h0D;
    localparam logic [7:0] CODE_HT = 8'h09;
    localparam logic [7:0] CODE_VT = 8'h0B;

    function automatic hex_digit_t hex_digit(input logic [7:0] b);
        hex_digit_t r;
        logic [7:0] d;
        r = '0;
        d = '0;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            d = b - CH_ZERO;
            r.ok = 1'b1;
        end else if (b >= CH_LO_A && b <= CH_LO_F) begin
            d = b - CH_LO_A + 8'd10;
            r.ok = 1'b1;
        end else if (b >= CH_UP_A && b <= CH_UP_F) begin
            d = b - CH_UP_A + 8'd10;
            r.ok = 1'b1;
        end
        r.value = d[3:0];
        return r;
    endfunction

endpackage

### rtl/string_literal_escape_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_literal_escape_decoder
// Decodes the body bytes of a C string literal: control escapes, hex and
// octal escapes, line splices, joined and lone quotes, end marker.
// ----------------------------------------------------------------------------
// Results: the result beats of an accepted input beat are registered into the buffer and offered from the next cycle.
// Throughput: one input beat per cycle while each gives at most one result
//   and m_ready is high; a beat with more results (up to 3) holds the input
//   until the single result port takes its last entry from the three-entry result buffer.
// Reset: synchronous active-low aresetn empties the buffer, returns decoding
//   to normal and sets report_quote_error to 1.
module string_literal_escape_decoder
    import sled_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_is_end,
    output logic       m_quote_error
);

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_ESCAPE,
        MODE_HEX,
        MODE_OCTAL,
        MODE_QUOTE
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [7:0] acc_reg, acc_next;
    logic [1:0] ocnt_reg, ocnt_next;
    logic       rqe_reg;

    res_t       slot_reg [MAX_RES];
    logic [1:0] cnt_reg;

    // candidate results in emit order: flush/flag, byte, trailing, end
    res_t       cand [4];
    logic [3:0] cand_en;
    res_t       list [MAX_RES];
    logic [2:0] n_res;

    logic       s_fire, m_fire;
    hex_digit_t hd;
    logic       is_oct;
    logic [7:0] oct_acc;
    logic [1:0] ocnt_inc;
    res_t       flag_res;
    res_t       end_res;

    assign m_valid       = (cnt_reg != 2'd0);
    assign m_out_byte    = slot_reg[0].data;
    assign m_is_end      = slot_reg[0].is_end;
    assign m_quote_error = slot_reg[0].qerr;
    assign s_ready       = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);
    assign s_fire        = s_valid && s_ready;
    assign m_fire        = m_valid && m_ready;

    assign hd       = hex_digit(s_in_byte);
    assign is_oct   = (s_in_byte >= CH_ZERO) && (s_in_byte <= CH_SEVEN);
    assign oct_acc  = {acc_reg[4:0], s_in_byte[2:0]};
    assign ocnt_inc = ocnt_reg + 2'd1;
    assign flag_res = '{data: 8'h00, is_end: 1'b0, qerr: 1'b1};
    assign end_res  = '{data: 8'h00, is_end: 1'b1, qerr: 1'b0};

    always_comb begin
        logic do_normal;
        do_normal = 1'b0;
        mode_next = mode_reg;
        acc_next  = acc_reg;
        ocnt_next = ocnt_reg;
        cand_en   = '0;
        cand[0]   = '{data: acc_reg, is_end: 1'b0, qerr: 1'b0};
        cand[1]   = '{data: s_in_byte, is_end: 1'b0, qerr: 1'b0};
        cand[2]   = '0;
        cand[3]   = end_res;

        unique case (mode_reg)
            MODE_ESCAPE: begin
                mode_next = MODE_NORMAL;
                unique case (s_in_byte)
                    CH_LO_B: begin cand_en[1] = 1'b1; cand[1].data = CODE_BS; end
                    CH_LO_F: begin cand_en[1] = 1'b1; cand[1].data = CODE_FF; end
                    CH_LO_N: begin cand_en[1] = 1'b1; cand[1].data = CODE_NL; end
                    CH_LO_R: begin cand_en[1] = 1'b1; cand[1].data = CODE_CR; end
                    CH_LO_T: begin cand_en[1] = 1'b1; cand[1].data = CODE_HT; end
                    CH_LO_V: begin cand_en[1] = 1'b1; cand[1].data = CODE_VT; end
                    CH_LO_X, CH_UP_X: begin
                        mode_next = MODE_HEX;
                        acc_next  = 8'h00;
                    end
                    CH_NL: begin
                        // line splice: drop
                    end
                    default: begin
                        if (is_oct) begin
                            mode_next = MODE_OCTAL;
                            acc_next  = {5'd0, s_in_byte[2:0]};
                            ocnt_next = 2'd1;
                        end else begin
                            cand_en[1] = 1'b1;
                        end
                    end
                endcase
            end
            MODE_HEX: begin
                if (hd.ok) begin
                    acc_next = {acc_reg[3:0], hd.value};
                end else begin
                    cand_en[0] = 1'b1;
                    acc_next   = 8'h00;
                    mode_next  = MODE_NORMAL;
                    do_normal  = 1'b1;
                end
            end
            MODE_OCTAL: begin
                if (is_oct && ocnt_reg != 2'd3) begin
                    acc_next  = oct_acc;
                    ocnt_next = ocnt_inc;
                    if (ocnt_inc == 2'd3) begin
                        // third digit closes the escape
                        cand_en[1]   = 1'b1;
                        cand[1].data = oct_acc;
                        acc_next     = 8'h00;
                        ocnt_next    = 2'd0;
                        mode_next    = MODE_NORMAL;
                    end
                end else begin
                    cand_en[0] = 1'b1;
                    acc_next   = 8'h00;
                    ocnt_next  = 2'd0;
                    mode_next  = MODE_NORMAL;
                    do_normal  = 1'b1;
                end
            end
            MODE_QUOTE: begin
                mode_next = MODE_NORMAL;
                if (s_in_byte != CH_QUOTE) begin
                    cand_en[0] = rqe_reg;
                    cand[0]    = flag_res;
                    do_normal  = 1'b1;
                end
            end
            default: begin
                mode_next = MODE_NORMAL;
                do_normal = 1'b1;
            end
        endcase

        if (do_normal) begin
            priority if (s_in_byte == CH_BSLASH) begin
                mode_next = MODE_ESCAPE;
            end else if (s_in_byte == CH_QUOTE) begin
                mode_next = MODE_QUOTE;
            end else begin
                cand_en[1] = 1'b1;
            end
        end

        if (s_in_last) begin
            if (mode_next == MODE_HEX || mode_next == MODE_OCTAL) begin
                cand_en[2] = 1'b1;
                cand[2]    = '{data: acc_next, is_end: 1'b0, qerr: 1'b0};
            end else if (mode_next == MODE_QUOTE) begin
                cand_en[2] = rqe_reg;
                cand[2]    = flag_res;
            end
            cand_en[3] = 1'b1;
            mode_next  = MODE_NORMAL;
            acc_next   = 8'h00;
            ocnt_next  = 2'd0;
        end
    end

    // pack enabled candidates into the result list
    always_comb begin
        n_res = 3'd0;
        for (int i = 0; i < MAX_RES; i++) begin
            list[i] = '0;
        end
        for (int i = 0; i < 4; i++) begin
            if (cand_en[i] && n_res < 3'(MAX_RES)) begin
                list[n_res[1:0]] = cand[i];
                n_res = n_res + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            acc_reg  <= 8'h00;
            ocnt_reg <= 2'd0;
            rqe_reg  <= 1'b1;
            cnt_reg  <= 2'd0;
        end else begin
            if (cfg_wr_en) begin
                rqe_reg <= cfg_wr_data;
            end
            // load a fresh list on accept, else advance on each taken beat
            if (s_fire) begin
                mode_reg <= mode_next;
                acc_reg  <= acc_next;
                ocnt_reg <= ocnt_next;
                cnt_reg  <= n_res[1:0];
                for (int i = 0; i < MAX_RES; i++) begin
                    slot_reg[i] <= list[i];
                end
            end else if (m_fire) begin
                cnt_reg <= cnt_reg - 2'd1;
                for (int i = 0; i < MAX_RES - 1; i++) begin
                    slot_reg[i] <= slot_reg[i + 1];
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg > 2'd1) |-> !s_ready)
        else $error("input accepted while results still pending");

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_in_last) |=> (m_valid && mode_reg == MODE_NORMAL && acc_reg == 8'h00))
        else $error("last beat did not close the literal");

    a_end_is_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_end) |-> (m_out_byte == 8'h00 && !m_quote_error))
        else $error("end marker carries data");

    a_octal_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg != MODE_OCTAL) |-> (ocnt_reg == 2'd0))
        else $error("octal digit count left over outside octal escape");
`endif

endmodule

### verif/string_literal_escape_decoder_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_literal_escape_decoder_chk
// Watches both channels of the literal decoder. Each accepted input beat is
// decoded by a local copy of the escape and quote logic, and the decoded
// beats are queued. Each accepted result beat is compared field by field
// against the oldest queued beat.
// ----------------------------------------------------------------------------
module string_literal_escape_decoder_chk
    import sled_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_byte,
    input  logic       m_is_end,
    input  logic       m_quote_error,
    output int         fail_count,
    output int         beats_due
);

    typedef enum logic [2:0] {
        MODE_PLAIN,
        MODE_ESC,
        MODE_HEX,
        MODE_OCT,
        MODE_QUOTE
    } decode_mode_t;

    decode_mode_t mode;
    logic [7:0]   acc;
    logic [1:0]   oct_digits;
    logic         flag_lone;
    res_t         decoded_q[$];
    int           beat_emits;

    task emit_beat(input logic [7:0] data, input logic is_end, input logic qerr);
        res_t r;
        r.data   = data;
        r.is_end = is_end;
        r.qerr   = qerr;
        if (beat_emits < int'(MAX_RES)) begin
            decoded_q.push_back(r);
            beat_emits++;
        end
    endtask

    task lone_quote();
        if (flag_lone)
            emit_beat(8'h00, 1'b0, 1'b1);
    endtask

    task plain_byte(input logic [7:0] b);
        if (b == CH_BSLASH)
            mode = MODE_ESC;
        else if (b == CH_QUOTE)
            mode = MODE_QUOTE;
        else
            emit_beat(b, 1'b0, 1'b0);
    endtask

    // {ok, nibble}
    function automatic logic [4:0] hex_lookup(input logic [7:0] b);
        logic [7:0] v;
        v = 8'h00;
        if (b >= CH_ZERO && b <= CH_NINE)
            v = b - CH_ZERO;
        else if (b >= CH_LO_A && b <= CH_LO_F)
            v = b - CH_LO_A + 8'd10;
        else if (b >= CH_UP_A && b <= CH_UP_F)
            v = b - CH_UP_A + 8'd10;
        else
            return 5'b0_0000;
        return {1'b1, v[3:0]};
    endfunction

    task decode_beat(input logic [7:0] b, input logic last);
        logic [4:0] h;
        beat_emits = 0;
        case (mode)
            MODE_ESC: begin
                mode = MODE_PLAIN;
                case (b)
                    CH_LO_B: emit_beat(CODE_BS, 1'b0, 1'b0);
                    CH_LO_F: emit_beat(CODE_FF, 1'b0, 1'b0);
                    CH_LO_N: emit_beat(CODE_NL, 1'b0, 1'b0);
                    CH_LO_R: emit_beat(CODE_CR, 1'b0, 1'b0);
                    CH_LO_T: emit_beat(CODE_HT, 1'b0, 1'b0);
                    CH_LO_V: emit_beat(CODE_VT, 1'b0, 1'b0);
                    CH_LO_X, CH_UP_X: begin
                        mode = MODE_HEX;
                        acc  = 8'h00;
                    end
                    CH_NL: ; // line splice: drop both
                    default: begin
                        if (b >= CH_ZERO && b <= CH_SEVEN) begin
                            mode       = MODE_OCT;
                            acc        = {5'b0, b[2:0]};
                            oct_digits = 2'd1;
                        end else begin
                            emit_beat(b, 1'b0, 1'b0);
                        end
                    end
                endcase
            end
            MODE_HEX: begin
                h = hex_lookup(b);
                if (h[4]) begin
                    acc = {acc[3:0], h[3:0]};
                end else begin
                    emit_beat(acc, 1'b0, 1'b0);
                    acc  = 8'h00;
                    mode = MODE_PLAIN;
                    plain_byte(b);
                end
            end
            MODE_OCT: begin
                if (b >= CH_ZERO && b <= CH_SEVEN && oct_digits < 2'd3) begin
                    acc = {acc[4:0], b[2:0]};
                    oct_digits++;
                    // third digit closes the escape at once
                    if (oct_digits == 2'd3) begin
                        emit_beat(acc, 1'b0, 1'b0);
                        acc        = 8'h00;
                        oct_digits = 2'd0;
                        mode       = MODE_PLAIN;
                    end
                end else begin
                    emit_beat(acc, 1'b0, 1'b0);
                    acc        = 8'h00;
                    oct_digits = 2'd0;
                    mode       = MODE_PLAIN;
                    plain_byte(b);
                end
            end
            MODE_QUOTE: begin
                mode = MODE_PLAIN;
                if (b != CH_QUOTE) begin
                    lone_quote();
                    plain_byte(b);
                end
            end
            default: begin
                mode = MODE_PLAIN;
                plain_byte(b);
            end
        endcase

        if (last) begin
            // flush a pending escape value or quote, then close the literal
            if (mode == MODE_HEX || mode == MODE_OCT)
                emit_beat(acc, 1'b0, 1'b0);
            else if (mode == MODE_QUOTE)
                lone_quote();
            emit_beat(8'h00, 1'b1, 1'b0);
            mode       = MODE_PLAIN;
            acc        = 8'h00;
            oct_digits = 2'd0;
        end
    endtask

    always @(posedge aclk) begin : watch
        res_t want;
        if (!aresetn) begin
            mode       = MODE_PLAIN;
            acc        = 8'h00;
            oct_digits = 2'd0;
            flag_lone  = 1'b1;
            decoded_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected beat: out_byte %02h is_end %0b quote_error %0b",
                           m_out_byte, m_is_end, m_quote_error);
                    fail_count++;
                end else begin
                    want = decoded_q.pop_front();
                    if (m_out_byte !== want.data) begin
                        $error("out_byte expected %02h, got %02h", want.data, m_out_byte);
                        fail_count++;
                    end
                    if (m_is_end !== want.is_end) begin
                        $error("is_end expected %0b, got %0b", want.is_end, m_is_end);
                        fail_count++;
                    end
                    if (m_quote_error !== want.qerr) begin
                        $error("quote_error expected %0b, got %0b", want.qerr, m_quote_error);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                decode_beat(s_in_byte, s_in_last);
            if (cfg_wr_en)
                flag_lone = cfg_wr_data;
        end
        beats_due = decoded_q.size();
    end

endmodule

### verif/string_literal_escape_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_literal_escape_decoder_tb
// Feeds literal bodies to the escape decoder: a directed set of escapes,
// splices and quote cases, then random literals built from plain bytes,
// escape sequences and quotes, under both settings of the lone-quote flag
// and with random idling on both channels. A checker beside the block does
// the comparison; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module string_literal_escape_decoder_tb;
    import sled_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_HOLD     = 4;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       s_valid     = 1'b0;
    logic [7:0] s_in_byte   = 8'h00;
    logic       s_in_last   = 1'b0;
    logic       m_ready     = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_out_byte;
    logic       m_is_end;
    logic       m_quote_error;

    int         fail_count;
    int         beats_due;
    int         quiet_cycles;
    int         bytes_sent;
    bit         idle_on;
    logic [7:0] lit_bytes[$];

    logic [7:0] esc_letters [0:9] = '{CH_LO_B, CH_LO_F, CH_LO_N, CH_LO_R, CH_LO_T,
                                      CH_LO_V, CH_BSLASH, CH_QUOTE, CH_NL, CH_NINE};

    always #6 aclk = ~aclk;

    string_literal_escape_decoder uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_in_last     (s_in_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_is_end      (m_is_end),
        .m_quote_error (m_quote_error)
    );

    string_literal_escape_decoder_chk chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_in_last     (s_in_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_is_end      (m_is_end),
        .m_quote_error (m_quote_error),
        .fail_count    (fail_count),
        .beats_due     (beats_due)
    );

    // Result side: stall in bursts while idling is on
    initial begin
        forever begin
            @(negedge aclk);
            if (idle_on && $urandom_range(0, 4) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge aclk);
            end
            m_ready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("string_literal_escape_decoder_tb: errors");
            $finish;
        end
    end

    task send_beat(input logic [7:0] b, input logic last);
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_in_byte = b;
        s_in_last = last;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task send_literal();
        for (int i = 0; i < lit_bytes.size(); i++)
            send_beat(lit_bytes[i], i == lit_bytes.size() - 1);
    endtask

    // Hold the input until every queued result has come, then let the block settle
    task hold_until_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (beats_due != 0) @(negedge aclk);
        repeat (DRAIN_HOLD) @(negedge aclk);
    endtask

    task write_quote_flag(input logic v);
        hold_until_drained();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    task random_literals(input int n_bytes, input bit allow_idle);
        int stop_at;
        int want_len;
        int pick;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            idle_on = allow_idle && ($urandom_range(0, 3) != 0);
            if (allow_idle && $urandom_range(0, 7) == 0)
                hold_until_drained();
            lit_bytes.delete();
            want_len = $urandom_range(1, 10);
            while (lit_bytes.size() < want_len) begin
                case ($urandom_range(0, 9))
                    0, 1: lit_bytes.push_back(8'($urandom_range(0, 255)));
                    2: lit_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
                    3: begin
                        lit_bytes.push_back(CH_BSLASH);
                        lit_bytes.push_back(esc_letters[$urandom_range(0, 9)]);
                    end
                    4: begin
                        lit_bytes.push_back(CH_BSLASH);
                        lit_bytes.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
                        repeat ($urandom_range(0, 4)) begin
                            pick = $urandom_range(0, 21);
                            if (pick < 10)
                                lit_bytes.push_back(CH_ZERO + 8'(pick));
                            else if (pick < 16)
                                lit_bytes.push_back(CH_LO_A + 8'(pick - 10));
                            else
                                lit_bytes.push_back(CH_UP_A + 8'(pick - 16));
                        end
                    end
                    5: begin
                        lit_bytes.push_back(CH_BSLASH);
                        repeat ($urandom_range(1, 3))
                            lit_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
                    end
                    6: begin
                        lit_bytes.push_back(CH_QUOTE);
                        lit_bytes.push_back(CH_QUOTE);
                    end
                    7: lit_bytes.push_back(CH_QUOTE);
                    8: lit_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    default: lit_bytes.push_back(8'($urandom_range(CH_UP_A, CH_LO_F)));
                endcase
            end
            send_literal();
        end
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        idle_on = 1'b1;

        // Directed literals, lone quotes flagged (reset setting)
        lit_bytes = {8'h00, 8'hFF};
        send_literal();
        // \v, long hex run closed by a joined quote pair at the end
        lit_bytes = {CH_BSLASH, CH_LO_V, CH_BSLASH, CH_UP_X, CH_LO_F, CH_UP_F, CH_NINE,
                     CH_QUOTE, CH_QUOTE};
        send_literal();
        // three-digit octal, then a plain digit
        lit_bytes = {CH_BSLASH, CH_ZERO + 8'd3, CH_ZERO + 8'd4, CH_SEVEN, CH_ZERO + 8'd6};
        send_literal();
        // octal cut short by an eight
        lit_bytes = {CH_BSLASH, CH_SEVEN, CH_ZERO + 8'd8};
        send_literal();
        // quote as the final body byte
        lit_bytes = {CH_QUOTE};
        send_literal();
        // line splice, then a dangling backslash
        lit_bytes = {CH_BSLASH, CH_NL, CH_BSLASH};
        send_literal();
        // hex escape with no digits at the end
        lit_bytes = {CH_BSLASH, CH_LO_X};
        send_literal();

        write_quote_flag(1'b0);
        random_literals(75, 1'b1);
        write_quote_flag(1'b1);
        random_literals(75, 1'b1);
        write_quote_flag(1'b0);
        idle_on = 1'b0;
        random_literals(75, 1'b0);

        hold_until_drained();
        if (fail_count == 0)
            $display("string_literal_escape_decoder_tb: clean");
        else
            $display("string_literal_escape_decoder_tb: errors");
        $finish;
    end

endmodule

### sim.f
rtl/sled_pkg.sv
rtl/string_literal_escape_decoder.sv
verif/string_literal_escape_decoder_chk.sv
verif/string_literal_escape_decoder_tb.sv
